// ===== rtl/cfgr_pkg.sv =====
// Shared types and constants for the crossfade gain ramp unit.
package cfgr_pkg;

  localparam int unsigned GainFrac = 23;
  localparam int unsigned GainBits = 24;

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_START = 3'd1,
    CMD_TRANS = 3'd2,
    CMD_DONE  = 3'd3,
    CMD_FLUSH = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PLAY = 2'd1,
    PH_FIN  = 2'd2,
    PH_FOUT = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FIN_DONE = 3'd1,
    ST_HELD     = 3'd2,
    ST_UNDERRUN = 3'd3,
    ST_EOS      = 3'd4
  } status_e;

  localparam logic [0:0] RegEnable = 1'b0;
  localparam logic [0:0] RegLength = 1'b1;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } back_state_e;

endpackage

// ===== rtl/cfgr_front.sv =====
// Input queue: accepts requests and stores them unchanged, oldest first.
module cfgr_front #(
  parameter int unsigned W = 80,
  parameter int unsigned Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         full_o,
  input  logic [W-1:0] data_i,
  output logic         avail_o,
  input  logic         take_i,
  output logic [W-1:0] data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  logic [W-1:0] mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign avail_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (take_i && avail_o) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i && !full_o) - (AW+1)'(take_i && avail_o);
    end
  end
endmodule

// ===== rtl/cfgr_back.sv =====
// Execution engine: phase machine, gain multiply and serial reciprocal.
module cfgr_back #(
  parameter int unsigned SB = 24,
  parameter int unsigned CB = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_en_i,
  input  logic [CB-1:0]        cfg_len_i,
  input  logic                 avail_i,
  output logic                 take_o,
  input  logic [2:0]           cmd_i,
  input  logic signed [SB-1:0] s_i,
  input  logic signed [SB-1:0] mix_i,
  input  logic                 acc_i,
  input  logic                 tflag_i,
  input  logic [CB-1:0]        flen_i,
  input  logic [CB-1:0]        left_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic signed [SB-1:0] sample_o,
  output logic                 valid_o,
  output logic [2:0]           status_o,
  output logic [1:0]           phase_o,
  output logic [CB-1:0]        flen_o
);
  import cfgr_pkg::*;
  localparam int unsigned PW = SB + GainBits + 1;
  localparam int unsigned NW = GainBits + 1;
  localparam int unsigned DW = (CB > NW) ? CB : NW;
  localparam int unsigned IW = $clog2(NW + 1);
  localparam logic [GainBits-1:0] One = GainBits'(1) << GainFrac;

  back_state_e st_q, st_d;
  phase_e ph_q;
  logic done_q, skip_q;
  logic [GainBits-1:0] gain_q, step_q;
  logic [CB-1:0] rem_q;
  logic signed [SB-1:0] mix_q;
  logic acc_q;
  logic signed [PW-1:0] prod_q;
  logic [DW-1:0] div_d_q, rr_q;
  logic [NW-1:0] num_q, qt_q;
  logic [IW-1:0] it_q;
  logic out_full_q;
  logic signed [SB-1:0] o_s_q;
  logic o_v_q;
  logic [2:0] o_st_q;
  logic [CB-1:0] o_fl_q;

  localparam logic signed [SB:0] SMax = (SB+1)'((64'sd1 <<< (SB-1)) - 1);
  localparam logic signed [SB:0] SMin = -SMax - 1;

  function automatic logic signed [SB-1:0] sat(input logic signed [SB:0] x);
    if (x > SMax) sat = SB'(SMax);
    else if (x < SMin) sat = SB'(SMin);
    else sat = x[SB-1:0];
  endfunction

  logic signed [PW-1:0] rnd;
  logic signed [SB-1:0] p;
  assign rnd = prod_q + PW'(1 << (GainFrac - 1));
  assign p = SB'(rnd >>> GainFrac);

  logic [DW:0] rtrial;
  assign rtrial = {rr_q, num_q[NW-1]} - {1'b0, div_d_q};

  assign take_o = (st_q == BK_IDLE) && avail_i && !out_full_q;
  assign empty_o = !out_full_q;
  assign sample_o = o_s_q;
  assign valid_o = o_v_q;
  assign status_o = o_st_q;
  assign phase_o = ph_q;
  assign flen_o = o_fl_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: if (take_o) st_d = BK_EXEC;
      BK_EXEC: st_d = ((it_q != '0) && (div_d_q != '0)) ? BK_DIV : BK_OUT;
      BK_MUL:  st_d = BK_OUT;
      BK_DIV:  if (it_q == IW'(NW)) st_d = BK_OUT;
      BK_OUT:  st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  logic signed [SB-1:0] r_s;
  logic r_v;
  logic [2:0] r_st;
  logic [CB-1:0] r_fl;
  logic r_mul;
  logic start_div;

  always_comb begin
    r_s = '0;
    r_v = 1'b0;
    r_st = ST_OK;
    r_fl = '0;
    r_mul = 1'b0;
    case (cmd_i)
      CMD_READ: begin
        r_s = acc_i ? mix_i : '0;
        r_st = done_q ? ST_EOS : ST_UNDERRUN;
        if (left_i != '0) begin
          case (ph_q)
            PH_PLAY: begin
              if (!skip_q && done_q && (acc_i || left_i <= rem_q)) begin
                r_st = ST_HELD;
              end else begin
                r_v = 1'b1;
                r_st = ST_OK;
                r_s = acc_i ? sat((SB+1)'(mix_i) + (SB+1)'(s_i)) : s_i;
              end
            end
            PH_FIN: begin
              if (rem_q == '0) begin
                r_st = ST_FIN_DONE;
              end else begin
                r_v = 1'b1;
                r_st = ST_OK;
                r_mul = 1'b1;
              end
            end
            PH_FOUT: begin
              r_v = 1'b1;
              r_st = ST_OK;
              r_mul = 1'b1;
            end
            default: ;
          endcase
        end
      end
      CMD_TRANS: if (ph_q == PH_PLAY && tflag_i) begin
        r_fl = (left_i < rem_q) ? left_i : rem_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      ph_q <= PH_IDLE;
      done_q <= 1'b0;
      skip_q <= 1'b0;
      gain_q <= '0;
      step_q <= '0;
      rem_q <= '0;
      out_full_q <= 1'b0;
      it_q <= '0;
    end else begin
      st_q <= st_d;
      if (pop_i && out_full_q) out_full_q <= 1'b0;
      case (st_q)
        BK_IDLE: if (take_o) begin
          mix_q <= mix_i;
          acc_q <= acc_i;
          prod_q <= PW'(s_i) * $signed({1'b0, gain_q});
          o_s_q <= r_s;
          o_v_q <= r_v;
          o_fl_q <= r_fl;
          o_st_q <= r_st;
          start_div <= r_mul;
          case (cmd_i)
            CMD_READ: if (left_i != '0) begin
              if (ph_q == PH_FIN) begin
                if (rem_q == '0) ph_q <= PH_PLAY;
                else rem_q <= rem_q - 1'b1;
              end else if (ph_q == PH_FOUT && rem_q != '0) begin
                rem_q <= rem_q - 1'b1;
              end
            end
            CMD_START: if (ph_q == PH_IDLE) begin
              if (tflag_i) begin
                gain_q <= '0;
                ph_q <= PH_FIN;
                rem_q <= flen_i;
                if (flen_i != '0) begin
                  div_d_q <= DW'(flen_i);
                  it_q <= IW'(1);
                end
              end else ph_q <= PH_PLAY;
            end
            CMD_TRANS: if (ph_q == PH_PLAY) begin
              if (tflag_i) begin
                gain_q <= One;
                ph_q <= PH_FOUT;
                skip_q <= 1'b0;
                if (left_i < rem_q) begin
                  rem_q <= left_i;
                  div_d_q <= DW'(left_i);
                  it_q <= IW'(1);
                end
              end else skip_q <= 1'b1;
            end
            CMD_DONE: begin
              done_q <= 1'b1;
              if (cfg_en_i) begin
                rem_q <= cfg_len_i;
                div_d_q <= DW'(cfg_len_i);
                it_q <= IW'(1);
              end else skip_q <= 1'b1;
            end
            CMD_FLUSH: ph_q <= PH_PLAY;
            default: ;
          endcase
        end
        BK_EXEC: begin
          if (start_div) begin
            o_s_q <= acc_q ? sat((SB+1)'(mix_q) + (SB+1)'(p)) : p;
            if (ph_q == PH_FIN)
              gain_q <= ((NW'(gain_q) + NW'(step_q)) > NW'(One)) ? One : gain_q + step_q;
            else
              gain_q <= (gain_q > step_q) ? gain_q - step_q : '0;
          end
          if (it_q != '0) begin
            if (div_d_q == '0) begin
              step_q <= One;
              it_q <= '0;
            end else begin
              num_q <= NW'(One) + NW'(div_d_q[DW-1:1]);
              rr_q <= '0;
              qt_q <= '0;
              it_q <= '0;
            end
          end
        end
        BK_DIV: begin
          if (it_q != IW'(NW)) begin
            if (!rtrial[DW]) begin
              rr_q <= rtrial[DW-1:0];
              qt_q <= {qt_q[NW-2:0], 1'b1};
            end else begin
              rr_q <= {rr_q[DW-2:0], num_q[NW-1]};
              qt_q <= {qt_q[NW-2:0], 1'b0};
            end
            num_q <= {num_q[NW-2:0], 1'b0};
            it_q <= it_q + 1'b1;
          end else begin
            step_q <= (qt_q > NW'(One)) ? One : qt_q[GainBits-1:0];
            it_q <= '0;
          end
        end
        BK_OUT: out_full_q <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/crossfade_gain_ramp_unit.sv =====
// Top level of the crossfade gain ramp unit.
// A request waits in a two-entry input queue until the engine is idle and its result
// register is free. The engine multiplies in the cycle it takes the request, for a ramped
// sample rounds and saturates in the next, and marks the result valid in state BK_OUT.
// Start, transition and done events that need a new step pass through a restoring divider
// first. One result register holds the answer until popped.
module crossfade_gain_ramp_unit #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [COUNT_BITS-1:0]        cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic [2:0]                   cmd_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic signed [SAMPLE_BITS-1:0] mix_in_i,
  input  logic                         accumulate_i,
  input  logic                         transition_flag_i,
  input  logic [COUNT_BITS-1:0]        fade_length_in_i,
  input  logic [COUNT_BITS-1:0]        samples_left_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                         sample_valid_o,
  output logic [2:0]                   status_o,
  output logic [1:0]                   phase_out_o,
  output logic [COUNT_BITS-1:0]        fade_length_out_o
);
  import cfgr_pkg::*;
  localparam int unsigned W = 3 + 2*SAMPLE_BITS + 2 + 2*COUNT_BITS;

  logic en_q;
  logic [COUNT_BITS-1:0] len_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
      len_q <= COUNT_BITS'(88200);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegEnable) en_q <= cfg_data_i[0];
      else len_q <= cfg_data_i;
    end
  end

  logic [W-1:0] qd;
  logic avail, take;
  cfgr_front #(.W(W), .Depth(2)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .data_i({cmd_i, sample_in_i, mix_in_i, accumulate_i, transition_flag_i,
             fade_length_in_i, samples_left_i}),
    .avail_o(avail), .take_i(take), .data_o(qd)
  );

  cfgr_back #(.SB(SAMPLE_BITS), .CB(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_en_i(en_q), .cfg_len_i(len_q),
    .avail_i(avail), .take_o(take),
    .cmd_i(qd[W-1 -: 3]),
    .s_i(qd[W-4 -: SAMPLE_BITS]),
    .mix_i(qd[W-4-SAMPLE_BITS -: SAMPLE_BITS]),
    .acc_i(qd[2*COUNT_BITS+1]),
    .tflag_i(qd[2*COUNT_BITS]),
    .flen_i(qd[2*COUNT_BITS-1 -: COUNT_BITS]),
    .left_i(qd[COUNT_BITS-1:0]),
    .empty_o(empty), .pop_i(pop),
    .sample_o(sample_out_o), .valid_o(sample_valid_o), .status_o(status_o),
    .phase_o(phase_out_o), .flen_o(fade_length_out_o)
  );

`ifndef SYNTHESIS
  a_no_valid_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && sample_valid_o) |-> (status_o == ST_OK))
    else $error("valid sample with nonzero status");
  a_hold_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(sample_out_o)))
    else $error("result changed while waiting");
`endif
endmodule
